// ----- rtl/wsd_pkg.sv -----
package wsd_pkg;

   localparam int unsigned OctetWidth  = 8;
   localparam int unsigned OpcodeWidth = 4;
   localparam int unsigned LenWidth    = 64;
   localparam int unsigned KeyWidth    = 32;

   localparam logic [6:0] LEN7_MAX   = 7'd125;
   localparam logic [6:0] LEN16_CODE = 7'd126;

   typedef struct packed {
      logic                  vld;
      logic [OctetWidth-1:0] octet;
   } beat_type;

   typedef struct packed {
      logic                   mask_error;
      logic                   empty_frame;
      logic                   final_fragment;
      logic [OpcodeWidth-1:0] frame_opcode;
   } tag_type;

endpackage

// ----- rtl/wsd_in_stage.sv -----
module wsd_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   output wsd_pkg::beat_type  beat,
   input  logic               beat_ready
);
   import wsd_pkg::*;

   logic                  vld_ff;
   logic                  vld_in;
   logic [OctetWidth-1:0] octet_ff;

   assign req_tready = !vld_ff || beat_ready;
   assign vld_in     = req_tvalid ? 1'b1 : (vld_ff && !beat_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_tready) begin
         vld_ff <= vld_in;
      end
      if (req_tready && req_tvalid) begin
         octet_ff <= req_tdata;
      end
   end

   assign beat.vld   = vld_ff;
   assign beat.octet = octet_ff;

endmodule

// ----- rtl/wsd_parser.sv -----
module wsd_parser (
   input  logic              clock,
   input  logic              reset,
   input  wsd_pkg::beat_type beat,
   output logic              beat_ready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_data,
   output wsd_pkg::tag_type  rsp_tag,
   output logic              rsp_last
);
   import wsd_pkg::*;

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_KEY  = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [2:0]             ext_count_ff, ext_count_in;
   logic                   fin_ff, fin_in;
   logic [OpcodeWidth-1:0] opcode_ff, opcode_in;
   logic [LenWidth-1:0]    rem_ff, rem_in;
   logic [KeyWidth-1:0]    key_ff, key_in;
   logic [1:0]             key_index_ff, key_index_in;
   logic                   halted_ff, halted_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OctetWidth-1:0]  data_ff, data_in;
   logic                   last_ff, last_in;
   logic                   empty_ff, empty_in;
   logic                   err_ff, err_in;
   logic [OpcodeWidth-1:0] rsp_opcode_ff;
   logic                   rsp_fin_ff;

   logic                   take;
   logic                   emit;
   logic [OctetWidth-1:0]  b;
   logic [OctetWidth-1:0]  key_byte;

   assign beat_ready = !rsp_valid_ff || rsp_tready;
   assign take       = beat.vld && beat_ready;
   assign b          = beat.octet;
   assign key_byte   = key_ff[{~key_index_ff, 3'b000} +: OctetWidth];

   always_comb begin
      phase_in     = phase_ff;
      ext_count_in = ext_count_ff;
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      rem_in       = rem_ff;
      key_in       = key_ff;
      key_index_in = key_index_ff;
      halted_in    = halted_ff;
      emit         = 1'b0;
      data_in      = '0;
      last_in      = 1'b0;
      empty_in     = 1'b0;
      err_in       = 1'b0;
      if (!halted_ff) begin
         unique case (phase_ff)
            PH_HDR1: begin
               if (!b[7]) begin
                  emit      = 1'b1;
                  last_in   = 1'b1;
                  err_in    = 1'b1;
                  halted_in = 1'b1;
                  phase_in  = PH_HDR0;
               end else if (b[6:0] <= LEN7_MAX) begin
                  rem_in       = {{(LenWidth-7){1'b0}}, b[6:0]};
                  ext_count_in = 3'd3;
                  phase_in     = PH_KEY;
               end else if (b[6:0] == LEN16_CODE) begin
                  rem_in       = '0;
                  ext_count_in = 3'd1;
                  phase_in     = PH_EXT;
               end else begin
                  rem_in       = '0;
                  ext_count_in = 3'd7;
                  phase_in     = PH_EXT;
               end
            end
            PH_EXT: begin
               rem_in = {rem_ff[LenWidth-OctetWidth-1:0], b};
               if (ext_count_ff == 3'd0) begin
                  ext_count_in = 3'd3;
                  phase_in     = PH_KEY;
               end else begin
                  ext_count_in = ext_count_ff - 3'd1;
               end
            end
            PH_KEY: begin
               key_in = {key_ff[KeyWidth-OctetWidth-1:0], b};
               if (ext_count_ff != 3'd0) begin
                  ext_count_in = ext_count_ff - 3'd1;
               end else begin
                  key_index_in = 2'd0;
                  if (rem_ff == '0) begin
                     emit     = 1'b1;
                     last_in  = 1'b1;
                     empty_in = 1'b1;
                     phase_in = PH_HDR0;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               emit         = 1'b1;
               rem_in       = rem_ff - {{(LenWidth-1){1'b0}}, 1'b1};
               data_in      = b ^ key_byte;
               last_in      = (rem_ff == {{(LenWidth-1){1'b0}}, 1'b1});
               key_index_in = key_index_ff + 2'd1;
               if (last_in) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               fin_in    = b[7];
               opcode_in = b[OpcodeWidth-1:0];
               phase_in  = PH_HDR1;
            end
         endcase
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         ext_count_ff <= '0;
         fin_ff       <= 1'b0;
         opcode_ff    <= '0;
         rem_ff       <= '0;
         key_ff       <= '0;
         key_index_ff <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff     <= phase_in;
            ext_count_ff <= ext_count_in;
            fin_ff       <= fin_in;
            opcode_ff    <= opcode_in;
            rem_ff       <= rem_in;
            key_ff       <= key_in;
            key_index_ff <= key_index_in;
            halted_ff    <= halted_in;
            rsp_valid_ff <= rsp_valid_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (take && emit) begin
         data_ff       <= data_in;
         last_ff       <= last_in;
         empty_ff      <= empty_in;
         err_ff        <= err_in;
         rsp_opcode_ff <= opcode_ff;
         rsp_fin_ff    <= fin_ff;
      end
   end

   assign rsp_tvalid             = rsp_valid_ff;
   assign rsp_data               = data_ff;
   assign rsp_last               = last_ff;
   assign rsp_tag.mask_error     = err_ff;
   assign rsp_tag.empty_frame    = empty_ff;
   assign rsp_tag.final_fragment = rsp_fin_ff;
   assign rsp_tag.frame_opcode   = rsp_opcode_ff;

`ifndef SYNTH
   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      take && halted_ff |=> !rsp_valid_ff)
      else $error("result produced after mask error");
   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && err_ff |-> halted_ff)
      else $error("mask error without halt");
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (empty_ff || err_ff) |-> last_ff)
      else $error("empty or error result not marked last");
   a_data_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> rem_ff != '0)
      else $error("payload phase with zero length left");
`endif

endmodule

// ----- rtl/websocket_frame_deframer_unit.sv -----
// An accepted request beat passes the input register, then the result register after
// the header state machine. Throughput: one byte per cycle while rsp_tready allows;
// only payload bytes, unmasked length bytes and empty frames' last key bytes respond.
// Reset: synchronous, active high; returns to the first header byte and clears halt.
// A mask error halts the unit and drops all bytes until reset.
module websocket_frame_deframer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data
   output logic [6:0] rsp_tuser,   // [3:0] frame_opcode, [4] final_fragment,
                                   // [5] empty_frame, [6] mask_error
   output logic       rsp_tlast
);
   import wsd_pkg::*;

   beat_type beat;
   tag_type  tag;
   logic     beat_ready;

   wsd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .beat       (beat),
      .beat_ready (beat_ready)
   );

   wsd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .beat_ready (beat_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_tdata),
      .rsp_tag    (tag),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tuser = tag;

endmodule

// ----- sim/websocket_frame_deframer_unit_test.sv -----
`timescale 1ns / 100ps

module websocket_frame_deframer_unit_test;
   import wsd_pkg::*;

   typedef enum logic [2:0] {
      HdrLead,
      HdrLen,
      ExtLen,
      MaskKey,
      Payload
   } parse_phase_type;

   typedef struct packed {
      logic [OctetWidth-1:0] data;
      tag_type               tag;
      logic                  last;
   } payload_beat_type;

   localparam int unsigned IdlePercent  = 30;
   localparam int unsigned CalmFrom     = 1800;
   localparam int unsigned CalmTo       = 2600;
   localparam int unsigned HoldOffAt    = 800;
   localparam int unsigned HoldOffLen   = 300;
   localparam int unsigned StreamTarget = 1700;
   localparam int unsigned DrainCycles  = 16;
   localparam int unsigned StallLimit   = 5000;

   localparam int unsigned LenAuto  = 0;
   localparam int unsigned LenExt16 = 1;
   localparam int unsigned LenExt64 = 2;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [6:0] rsp_tuser;
   logic       rsp_tlast;

   logic [7:0]       octet_q[$];
   payload_beat_type unmasked_q[$];
   bit               failed = 1'b0;

   parse_phase_type       phase = HdrLead;
   logic [2:0]            field_left = '0;
   logic                  fin_bit = 1'b0;
   logic [OpcodeWidth-1:0] opcode = '0;
   logic [LenWidth-1:0]   bytes_left = '0;
   logic [KeyWidth-1:0]   key_word = '0;
   logic [1:0]            key_pos = '0;
   logic                  halted = 1'b0;

   websocket_frame_deframer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void push_unmasked(logic [7:0] data, logic last, logic empty,
                                         logic err);
      payload_beat_type b;
      b.data               = data;
      b.tag.mask_error     = err;
      b.tag.empty_frame    = empty;
      b.tag.final_fragment = fin_bit;
      b.tag.frame_opcode   = opcode;
      b.last               = last;
      unmasked_q.push_back(b);
   endfunction

   function automatic void deframe_octet(logic [7:0] b);
      logic [7:0] kb;
      if (halted) return;
      case (phase)
         HdrLen: begin
            if (!b[7]) begin
               push_unmasked('0, 1'b1, 1'b0, 1'b1);
               halted = 1'b1;
               phase  = HdrLead;
            end else if (b[6:0] <= LEN7_MAX) begin
               bytes_left = {57'd0, b[6:0]};
               field_left = 3'd3;
               phase      = MaskKey;
            end else if (b[6:0] == LEN16_CODE) begin
               bytes_left = '0;
               field_left = 3'd1;
               phase      = ExtLen;
            end else begin
               bytes_left = '0;
               field_left = 3'd7;
               phase      = ExtLen;
            end
         end
         ExtLen: begin
            bytes_left = {bytes_left[LenWidth-9:0], b};
            if (field_left == 0) begin
               field_left = 3'd3;
               phase      = MaskKey;
            end else begin
               field_left = field_left - 3'd1;
            end
         end
         MaskKey: begin
            key_word = {key_word[KeyWidth-9:0], b};
            if (field_left != 0) begin
               field_left = field_left - 3'd1;
            end else begin
               key_pos = '0;
               if (bytes_left == 0) begin
                  push_unmasked('0, 1'b1, 1'b1, 1'b0);
                  phase = HdrLead;
               end else begin
                  phase = Payload;
               end
            end
         end
         Payload: begin
            kb         = key_word[8*(3-key_pos) +: 8];
            bytes_left = bytes_left - 64'd1;
            push_unmasked(b ^ kb, bytes_left == 0, 1'b0, 1'b0);
            key_pos = key_pos + 2'd1;
            if (bytes_left == 0) phase = HdrLead;
         end
         default: begin
            fin_bit = b[7];
            opcode  = b[3:0];
            phase   = HdrLen;
         end
      endcase
   endfunction

   task automatic queue_frame(logic [7:0] lead, logic [63:0] len, int unsigned coding);
      int unsigned i;
      octet_q.push_back(lead);
      if (coding == LenAuto && len <= LEN7_MAX) begin
         octet_q.push_back({1'b1, len[6:0]});
      end else if (coding != LenExt64 && len < 64'h10000) begin
         octet_q.push_back({1'b1, LEN16_CODE});
         octet_q.push_back(len[15:8]);
         octet_q.push_back(len[7:0]);
      end else begin
         octet_q.push_back(8'hff);
         for (i = 0; i < 8; i++) octet_q.push_back(len[63-8*i -: 8]);
      end
      for (i = 0; i < 4; i++) octet_q.push_back(8'($urandom_range(255)));
      for (i = 0; i < len; i++) octet_q.push_back(8'($urandom_range(255)));
   endtask

   task automatic queue_random_frame();
      int unsigned pick;
      logic [7:0]  lead;
      pick = $urandom_range(99);
      lead = 8'($urandom_range(255));
      if (pick < 50) queue_frame(lead, 64'($urandom_range(8)), LenAuto);
      else if (pick < 75) queue_frame(lead, 64'($urandom_range(125)), LenAuto);
      else if (pick < 87) queue_frame(lead, 64'($urandom_range(300)), LenExt16);
      else if (pick < 97) queue_frame(lead, 64'($urandom_range(300)), LenExt64);
      else queue_frame(lead, 64'($urandom_range(126, 700)), LenAuto);
   endtask

   always @(posedge clock) begin : driver
      int unsigned cycle;
      if (reset) begin
         req_tvalid <= 1'b0;
         cycle = 0;
      end else begin
         cycle++;
         if (req_tvalid && req_tready) deframe_octet(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (octet_q.size() != 0 &&
                ((cycle >= CalmFrom && cycle < CalmTo) ||
                 $urandom_range(99) >= IdlePercent)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= octet_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      int unsigned      cycle;
      int unsigned      hold_left;
      payload_beat_type exp_beat;
      tag_type          got_tag;
      if (reset) begin
         cycle     = 0;
         hold_left = 0;
      end else begin
         cycle++;
         if (rsp_tvalid && rsp_tready) begin
            got_tag = tag_type'(rsp_tuser);
            if (unmasked_q.size() == 0) begin
               $error("unexpected beat: data %h tuser %h tlast %b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               failed = 1'b1;
            end else begin
               exp_beat = unmasked_q.pop_front();
               if (rsp_tdata !== exp_beat.data) begin
                  $error("data: expected %h, got %h", exp_beat.data, rsp_tdata);
                  failed = 1'b1;
               end
               if (got_tag.frame_opcode !== exp_beat.tag.frame_opcode) begin
                  $error("frame_opcode: expected %h, got %h",
                         exp_beat.tag.frame_opcode, got_tag.frame_opcode);
                  failed = 1'b1;
               end
               if (got_tag.final_fragment !== exp_beat.tag.final_fragment) begin
                  $error("final_fragment: expected %b, got %b",
                         exp_beat.tag.final_fragment, got_tag.final_fragment);
                  failed = 1'b1;
               end
               if (rsp_tlast !== exp_beat.last) begin
                  $error("last: expected %b, got %b", exp_beat.last, rsp_tlast);
                  failed = 1'b1;
               end
               if (got_tag.empty_frame !== exp_beat.tag.empty_frame) begin
                  $error("empty_frame: expected %b, got %b",
                         exp_beat.tag.empty_frame, got_tag.empty_frame);
                  failed = 1'b1;
               end
               if (got_tag.mask_error !== exp_beat.tag.mask_error) begin
                  $error("mask_error: expected %b, got %b",
                         exp_beat.tag.mask_error, got_tag.mask_error);
                  failed = 1'b1;
               end
            end
         end
         if (cycle == HoldOffAt) hold_left = HoldOffLen;
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= (cycle >= CalmFrom && cycle < CalmTo) ||
                          $urandom_range(99) >= IdlePercent;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      int unsigned quiet;
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= StallLimit) begin
            $display("websocket_frame_deframer_unit_test failed");
            $finish;
         end
      end
   end

   initial begin
      // empty ping, one-byte continuation under an all-ones key, extended codings
      queue_frame(8'h89, 64'd0, LenAuto);
      octet_q.push_back(8'h00);
      octet_q.push_back(8'h81);
      repeat (4) octet_q.push_back(8'hff);
      octet_q.push_back(8'hff);
      queue_frame(8'h7f, 64'd1, LenExt16);
      queue_frame(8'hf2, 64'd0, LenExt64);
      while (octet_q.size() < StreamTarget) queue_random_frame();
      // unmasked frame halts the parser; trailing bytes must be dropped
      octet_q.push_back(8'h8a);
      octet_q.push_back(8'h05);
      repeat (6) octet_q.push_back(8'($urandom_range(255)));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (octet_q.size() != 0 || req_tvalid);
      while (unmasked_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (!failed) begin
         $display("websocket_frame_deframer_unit_test passed");
      end else begin
         $display("websocket_frame_deframer_unit_test failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/wsd_pkg.sv
rtl/wsd_in_stage.sv
rtl/wsd_parser.sv
rtl/websocket_frame_deframer_unit.sv
sim/websocket_frame_deframer_unit_test.sv
